// ===== sv/dst_rule_check_unit_assert.svh =====
// ----------------------------------------------------------------------------
// DST rule check assertion macros
// Shared concurrent assertion forms for the daylight saving time rule check.
// ----------------------------------------------------------------------------
`ifndef DST_RULE_CHECK_UNIT_ASSERT_SVH
`define DST_RULE_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DRC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dst_rule_check_unit: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DRC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dst_rule_check_unit: assertion failed");

`endif

// ===== sv/dst_pkg.sv =====
// ----------------------------------------------------------------------------
// DST rule check package
// Configuration types, pipeline load controls, calendar tables and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

    localparam logic signed [28:0] DAY_MS_S    = 29'sd86400000;
    localparam logic signed [28:0] DAY_MS_M1_S = 29'sd86399999;

    typedef enum logic [2:0] {
        REG_DST_ENABLE     = 3'd0,
        REG_ABSOLUTE_RULES = 3'd1,
        REG_START_RULE     = 3'd2,
        REG_START_TIME_MS  = 3'd3,
        REG_END_RULE       = 3'd4,
        REG_END_TIME_MS    = 3'd5,
        REG_DST_BIAS       = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic               dst_enable;
        logic               absolute_rules;
        logic [9:0]         start_rule;
        logic [26:0]        start_time_ms;
        logic [9:0]         end_rule;
        logic [26:0]        end_time_ms;
        logic signed [11:0] dst_bias_minutes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dst_enable:       1'b1,
        absolute_rules:   1'b0,
        start_rule:       10'd0,
        start_time_ms:    27'd0,
        end_rule:         10'd0,
        end_time_ms:      27'd0,
        dst_bias_minutes: 12'sd0
    };

    typedef struct packed {
        logic ld_p2;
        logic ld_p3;
    } stage_en_t;

    // Day of year of the last day of a month, with -1 for month zero.
    function automatic logic signed [9:0] cum_day(input logic [3:0] month, input logic leap);
        logic signed [9:0] d;
        case (month)
            4'd0:    d = -10'sd1;
            4'd1:    d = 10'sd30;
            4'd2:    d = leap ? 10'sd59  : 10'sd58;
            4'd3:    d = leap ? 10'sd90  : 10'sd89;
            4'd4:    d = leap ? 10'sd120 : 10'sd119;
            4'd5:    d = leap ? 10'sd151 : 10'sd150;
            4'd6:    d = leap ? 10'sd181 : 10'sd180;
            4'd7:    d = leap ? 10'sd212 : 10'sd211;
            4'd8:    d = leap ? 10'sd243 : 10'sd242;
            4'd9:    d = leap ? 10'sd273 : 10'sd272;
            4'd10:   d = leap ? 10'sd304 : 10'sd303;
            4'd11:   d = leap ? 10'sd334 : 10'sd333;
            4'd12:   d = leap ? 10'sd365 : 10'sd364;
            default: d = 10'sd0;
        endcase
        return d;
    endfunction

    // Remainder modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [9:0] v);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
        b = 4'(a[2:0]) + 4'(a[4:3]);
        if (b >= 4'd7)
        begin
            b = b - 4'd7;
        end
        return b[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/dst_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// DST rule check configuration registers
// Register file written through the configuration transaction channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_cfg_regs
    import dst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [26:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DST_ENABLE:     cfg_next.dst_enable       = cfg_data[0];
                REG_ABSOLUTE_RULES: cfg_next.absolute_rules   = cfg_data[0];
                REG_START_RULE:     cfg_next.start_rule       = cfg_data[9:0];
                REG_START_TIME_MS:  cfg_next.start_time_ms    = cfg_data;
                REG_END_RULE:       cfg_next.end_rule         = cfg_data[9:0];
                REG_END_TIME_MS:    cfg_next.end_time_ms      = cfg_data;
                REG_DST_BIAS:       cfg_next.dst_bias_minutes = $signed(cfg_data[11:0]);
                default:            cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dst_rule_day.sv =====
// ----------------------------------------------------------------------------
// DST rule transition day
// Two pipeline stages that turn a week/weekday/month rule into a day of year.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_rule_day
    import dst_pkg::*;
(
    input  logic               clk,
    input  stage_en_t          en,
    input  logic [9:0]         rule,
    input  logic [8:0]         base,
    input  logic               leap,
    output logic signed [10:0] day
);

    logic [3:0]         month;
    logic [2:0]         week;
    logic [2:0]         wday;
    logic signed [9:0]  first_cum;
    logic [8:0]         first_day_next;
    logic [9:0]         day_sum;
    logic [2:0]         mdow_next;
    logic signed [9:0]  limit_next;

    logic [8:0]         first_day_reg;
    logic [2:0]         mdow_reg;
    logic signed [9:0]  limit_reg;

    logic signed [4:0]  wday_diff;
    logic signed [4:0]  week_adj;
    logic signed [10:0] day_raw;
    logic signed [10:0] day_next;
    logic signed [10:0] day_reg;

    assign month = rule[9:6];
    assign week  = rule[5:3];
    assign wday  = rule[2:0];

    assign first_cum      = cum_day(month - 4'd1, leap);
    assign first_day_next = 9'(first_cum + 10'sd1);
    assign day_sum        = 10'(first_day_next) + 10'(base);
    assign mdow_next      = mod7(day_sum);
    assign limit_next     = cum_day(month, leap);

    always_ff @(posedge clk)
    begin
        if (en.ld_p2)
        begin
            first_day_reg <= first_day_next;
            mdow_reg      <= mdow_next;
            limit_reg     <= limit_next;
        end
    end

    assign wday_diff = $signed({2'b00, wday}) - $signed({2'b00, mdow_reg});
    assign week_adj  = (mdow_reg <= wday) ? $signed({2'b00, week}) - 5'sd1
                                          : $signed({2'b00, week});
    assign day_raw   = $signed({2'b00, first_day_reg}) + 11'(wday_diff)
                     + 11'(week_adj) * 11'sd7;
    assign day_next  = (week == 3'd5 && day_raw > 11'(limit_reg)) ? day_raw - 11'sd7
                                                                 : day_raw;

    always_ff @(posedge clk)
    begin
        if (en.ld_p3)
        begin
            day_reg <= day_next;
        end
    end

    assign day = day_reg;

endmodule

`default_nettype wire

// ===== sv/dst_rule_check_unit.sv =====
// ----------------------------------------------------------------------------
// DST rule check unit
// Decides whether a local time lies inside the daylight saving period.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    year_since_1900, day_of_year, hour,
//                                   minute, second
//   output   out_valid / out_ready  in_dst
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction is accepted per cycle while the output is not stalled; its
// result is presented from the fourth stage register.
// The four pipeline stages are: rule day base and time sums,
// weekday of the month start and millisecond products, transition day and end
// time wrap, and the final comparison.
// Reset clears all stage valid bits and loads the configuration reset values.
// A stalled output holds each stage that is full; an empty stage still fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dst_rule_check_unit_assert.svh"

module dst_rule_check_unit
    import dst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [26:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  year_since_1900,
    input  logic [8:0]  day_of_year,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        in_dst
);

    cfg_t      cfg;
    stage_en_t stage_en;

    logic valid_p1_reg, valid_p2_reg, valid_p3_reg, valid_p4_reg;
    logic ready_p1, ready_p2, ready_p3, ready_p4;
    logic in_acc, out_acc;
    logic [3:0] stage_valid;

    logic [7:0]         year_m1;
    logic [8:0]         base_next;
    logic               leap_next;
    logic [16:0]        secs_next;
    logic signed [27:0] bias_ms_next;
    logic [8:0]         base_p1_reg;
    logic               leap_p1_reg;
    logic [8:0]         yday_p1_reg;
    logic [16:0]        secs_p1_reg;
    logic signed [27:0] bias_ms_p1_reg;

    logic [26:0]        ms_next;
    logic signed [28:0] ems_raw_next;
    logic [8:0]         yday_p2_reg;
    logic [26:0]        ms_p2_reg;
    logic signed [28:0] ems_raw_p2_reg;

    logic signed [28:0] ems_next;
    logic [8:0]         yday_p3_reg;
    logic [26:0]        ms_p3_reg;
    logic signed [28:0] ems_p3_reg;

    logic signed [10:0] start_day;
    logic signed [10:0] end_day;
    logic signed [10:0] yday_s;
    logic [3:0]         start_month;
    logic [3:0]         end_month;
    logic               cfg_ok;
    logic               time_after_start;
    logic               time_before_end;
    logic               in_dst_next;
    logic               in_dst_reg;

    dst_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Each stage advances when it is empty or the stage after it advances.
    assign ready_p4 = !valid_p4_reg || out_ready;
    assign ready_p3 = !valid_p3_reg || ready_p4;
    assign ready_p2 = !valid_p2_reg || ready_p3;
    assign ready_p1 = !valid_p1_reg || ready_p2;

    assign in_ready       = ready_p1;
    assign out_valid      = valid_p4_reg;
    assign in_dst         = in_dst_reg;
    assign in_acc         = in_valid && in_ready;
    assign out_acc        = out_valid && out_ready;
    assign stage_valid    = {valid_p4_reg, valid_p3_reg, valid_p2_reg, valid_p1_reg};
    assign stage_en.ld_p2 = ready_p2;
    assign stage_en.ld_p3 = ready_p3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_p1_reg <= 1'b0;
            valid_p2_reg <= 1'b0;
            valid_p3_reg <= 1'b0;
            valid_p4_reg <= 1'b0;
        end
        else
        begin
            if (ready_p1)
            begin
                valid_p1_reg <= in_valid;
            end
            if (ready_p2)
            begin
                valid_p2_reg <= valid_p1_reg;
            end
            if (ready_p3)
            begin
                valid_p3_reg <= valid_p2_reg;
            end
            if (ready_p4)
            begin
                valid_p4_reg <= valid_p3_reg;
            end
        end
    end

    // The weekday base folds 365 days per year into one day per year plus leap days.
    assign year_m1      = year_since_1900 - 8'd1;
    assign base_next    = (year_since_1900 == 8'd0) ? 9'd0
                        : 9'(year_since_1900) + 9'(year_m1 >> 2) + 9'd1;
    assign leap_next    = (year_since_1900[1:0] == 2'b00);
    assign secs_next    = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
    assign bias_ms_next = 28'($signed(cfg.dst_bias_minutes)) * 28'sd60000;

    always_ff @(posedge clk)
    begin
        if (ready_p1)
        begin
            base_p1_reg    <= base_next;
            leap_p1_reg    <= leap_next;
            yday_p1_reg    <= day_of_year;
            secs_p1_reg    <= secs_next;
            bias_ms_p1_reg <= bias_ms_next;
        end
    end

    dst_rule_day u_start_day (
        .clk  (clk),
        .en   (stage_en),
        .rule (cfg.start_rule),
        .base (base_p1_reg),
        .leap (leap_p1_reg),
        .day  (start_day)
    );

    dst_rule_day u_end_day (
        .clk  (clk),
        .en   (stage_en),
        .rule (cfg.end_rule),
        .base (base_p1_reg),
        .leap (leap_p1_reg),
        .day  (end_day)
    );

    assign ms_next      = 27'(secs_p1_reg) * 27'd1000;
    assign ems_raw_next = $signed({2'b00, cfg.end_time_ms}) + 29'(bias_ms_p1_reg);

    always_ff @(posedge clk)
    begin
        if (ready_p2)
        begin
            yday_p2_reg    <= yday_p1_reg;
            ms_p2_reg      <= ms_next;
            ems_raw_p2_reg <= ems_raw_next;
        end
    end

    always_comb
    begin
        if (ems_raw_p2_reg < 29'sd0)
        begin
            ems_next = ems_raw_p2_reg + DAY_MS_M1_S;
        end
        else if (ems_raw_p2_reg >= DAY_MS_S)
        begin
            ems_next = ems_raw_p2_reg - DAY_MS_M1_S;
        end
        else
        begin
            ems_next = ems_raw_p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_p3)
        begin
            yday_p3_reg <= yday_p2_reg;
            ms_p3_reg   <= ms_p2_reg;
            ems_p3_reg  <= ems_next;
        end
    end

    assign start_month      = cfg.start_rule[9:6];
    assign end_month        = cfg.end_rule[9:6];
    assign cfg_ok           = cfg.dst_enable && !cfg.absolute_rules
                           && start_month != 4'd0 && start_month <= 4'd12
                           && end_month != 4'd0 && end_month <= 4'd12;
    assign yday_s           = $signed({2'b00, yday_p3_reg});
    assign time_after_start = (ms_p3_reg >= cfg.start_time_ms);
    assign time_before_end  = ($signed({2'b00, ms_p3_reg}) < ems_p3_reg);

    always_comb
    begin
        if (yday_s == start_day)
        begin
            in_dst_next = time_after_start;
        end
        else
        begin
            in_dst_next = time_before_end;
        end
        if (start_day < end_day)
        begin
            if (yday_s < start_day || yday_s > end_day)
            begin
                in_dst_next = 1'b0;
            end
            else if (yday_s > start_day && yday_s < end_day)
            begin
                in_dst_next = 1'b1;
            end
        end
        else
        begin
            if (yday_s < end_day || yday_s > start_day)
            begin
                in_dst_next = 1'b1;
            end
            else if (yday_s > end_day && yday_s < start_day)
            begin
                in_dst_next = 1'b0;
            end
        end
        if (!cfg_ok)
        begin
            in_dst_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_p4)
        begin
            in_dst_reg <= in_dst_next;
        end
    end

    `DRC_ASSERT_IMPL(a_stall_only_from_output, !in_ready, out_valid && !out_ready)
    `DRC_ASSERT_NEXT(a_occupancy, 1'b1,
        $countones(stage_valid) == $past($countones(stage_valid)) + $past(in_acc) - $past(out_acc))
    `DRC_ASSERT_IMPL(a_start_day_range, valid_p3_reg && cfg_ok,
        start_day >= -11'sd7 && start_day <= 11'sd391)
    `DRC_ASSERT_IMPL(a_end_day_range, valid_p3_reg && cfg_ok,
        end_day >= -11'sd7 && end_day <= 11'sd391)

endmodule

`default_nettype wire

// ===== tb/dst_rule_check_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DST rule check unit testbench
// Sends local time stamps through the valid/ready input channel under a
// series of rule settings and compares every in_dst result, in order, with a
// calendar computation of the daylight saving period kept in the testbench.
// Settings cover disabled and absolute rules, missing or invalid months, odd
// week and weekday codes, southern ordering and both end time wraps.
// ----------------------------------------------------------------------------
module dst_rule_check_unit_test
    import dst_pkg::*;
();

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] yr;
        logic [8:0] yday;
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
    } stamp_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [26:0] cfg_data = 27'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  year_since_1900 = 8'd0;
    logic [8:0]  day_of_year = 9'd0;
    logic [4:0]  hour = 5'd0;
    logic [5:0]  minute = 6'd0;
    logic [5:0]  second = 6'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        in_dst;

    cfg_t   rules;
    stamp_t stamp_q[$];
    logic   pending_in_dst[$];
    logic   in_taken = 1'b0;
    int     send_idle_pct = 22;
    int     recv_idle_pct = 79;
    int     setting_count = 0;
    int     mismatch_count = 0;

    dst_rule_check_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .year_since_1900(year_since_1900),
        .day_of_year    (day_of_year),
        .hour           (hour),
        .minute         (minute),
        .second         (second),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .in_dst         (in_dst)
    );

    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic longint month_last_day(input longint m, input bit leap);
        longint d;
        case (m)
            0:       d = -1;
            1:       d = 30;
            2:       d = 58;
            3:       d = 89;
            4:       d = 119;
            5:       d = 150;
            6:       d = 180;
            7:       d = 211;
            8:       d = 242;
            9:       d = 272;
            10:      d = 303;
            11:      d = 333;
            default: d = 364;
        endcase
        if (leap && m >= 2)
        begin
            d = d + 1;
        end
        return d;
    endfunction

    // The month must be 1 to 12 here.
    function automatic longint transition_day(input logic [7:0] yr, input logic [9:0] rule);
        longint y;
        longint m;
        longint wk;
        longint wd;
        longint d;
        longint q;
        longint lin;
        longint w;
        bit     leap;
        y = longint'(yr);
        m = longint'(rule[9:6]);
        wk = longint'(rule[5:3]);
        wd = longint'(rule[2:0]);
        leap = (yr[1:0] == 2'b00);
        d = 1 + month_last_day(m - 1, leap);
        q = (y >= 1) ? (y - 1) / 4 : -((4 - y) / 4);
        lin = d + (y - 70) * 365 + q - 13;
        w = lin % 7;
        if (w < 0)
        begin
            w = w + 7;
        end
        if (w <= wd)
        begin
            d = d + (wd - w) + (wk - 1) * 7;
        end
        else
        begin
            d = d + (wd - w) + wk * 7;
        end
        if (wk == 5 && d > month_last_day(m, leap))
        begin
            d = d - 7;
        end
        return d;
    endfunction

    function automatic longint biased_end_ms();
        longint v;
        v = longint'(rules.end_time_ms)
            + longint'($signed(rules.dst_bias_minutes)) * 60000;
        if (v < 0)
        begin
            v = v + 86399999;
        end
        else if (v >= 86400000)
        begin
            v = v - 86399999;
        end
        return v;
    endfunction

    function automatic bit rule_months_valid();
        return rules.start_rule[9:6] != 4'd0 && rules.start_rule[9:6] <= 4'd12
            && rules.end_rule[9:6] != 4'd0 && rules.end_rule[9:6] <= 4'd12;
    endfunction

    function automatic logic dst_in_force(input stamp_t s);
        longint sday;
        longint eday;
        longint yday;
        longint ms;
        if (!rules.dst_enable || rules.absolute_rules || !rule_months_valid())
        begin
            return 1'b0;
        end
        sday = transition_day(s.yr, rules.start_rule);
        eday = transition_day(s.yr, rules.end_rule);
        yday = s.yday;
        if (sday < eday)
        begin
            if (yday < sday || yday > eday)
            begin
                return 1'b0;
            end
            if (yday > sday && yday < eday)
            begin
                return 1'b1;
            end
        end
        else
        begin
            if (yday < eday || yday > sday)
            begin
                return 1'b1;
            end
            if (yday > eday && yday < sday)
            begin
                return 1'b0;
            end
        end
        ms = 1000 * (longint'(s.sc) + 60 * longint'(s.mn) + 3600 * longint'(s.hr));
        if (yday == sday)
        begin
            return ms >= longint'(rules.start_time_ms);
        end
        return ms < biased_end_ms();
    endfunction

    function automatic stamp_t random_stamp();
        stamp_t s;
        longint d;
        longint t;
        bit     at_end;
        s.yr = roll(85) ? 8'($urandom_range(199, 70)) : 8'($urandom_range(255, 0));
        if (rule_months_valid() && roll(55))
        begin
            at_end = 1'($urandom_range(1, 0));
            d = transition_day(s.yr, at_end ? rules.end_rule : rules.start_rule);
            t = longint'($urandom_range(2, 0));
            d = d + t - 1;
            s.yday = (d < 0) ? 9'd0 : 9'(d);
            t = longint'($urandom_range(4, 0));
            t = t - 2 + (at_end ? biased_end_ms() : longint'(rules.start_time_ms)) / 1000;
            if (t < 0)
            begin
                t = 0;
            end
            if (t > 86399)
            begin
                t = 86399;
            end
            s.hr = 5'(t / 3600);
            s.mn = 6'((t / 60) % 60);
            s.sc = 6'(t % 60);
        end
        else
        begin
            s.yday = roll(95) ? 9'($urandom_range(365, 0)) : 9'($urandom_range(511, 0));
            if (roll(90))
            begin
                s.hr = 5'($urandom_range(23, 0));
                s.mn = 6'($urandom_range(59, 0));
                s.sc = 6'($urandom_range(60, 0));
            end
            else
            begin
                s.hr = 5'($urandom_range(31, 0));
                s.mn = 6'($urandom_range(63, 0));
                s.sc = 6'($urandom_range(63, 0));
            end
        end
        return s;
    endfunction

    function automatic logic [9:0] make_rule(input int mon, input int wk, input int wd);
        return {4'(mon), 3'(wk), 3'(wd)};
    endfunction

    function automatic logic [9:0] random_rule();
        logic [3:0] mon;
        logic [2:0] wk;
        logic [2:0] wd;
        mon = roll(85) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15, 0));
        wk = roll(85) ? 3'($urandom_range(5, 1)) : 3'($urandom_range(7, 0));
        wd = roll(90) ? 3'($urandom_range(6, 0)) : 3'($urandom_range(7, 0));
        return {mon, wk, wd};
    endfunction

    function automatic logic [26:0] random_time_ms();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30)
        begin
            return 27'($urandom_range(86399, 0) * 1000);
        end
        else if (r < 80)
        begin
            return 27'($urandom_range(86399999, 0));
        end
        else if (r < 90)
        begin
            return roll(50) ? 27'd0 : 27'd86399999;
        end
        return 27'($urandom);
    endfunction

    // Bits above the register width carry random values.
    function automatic logic [26:0] pad(input logic [26:0] v, input int w);
        logic [26:0] upper;
        upper = 27'($urandom) & ~((27'd1 << w) - 27'd1);
        return v | upper;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [26:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_DST_ENABLE:     rules.dst_enable = data[0];
            REG_ABSOLUTE_RULES: rules.absolute_rules = data[0];
            REG_START_RULE:     rules.start_rule = data[9:0];
            REG_START_TIME_MS:  rules.start_time_ms = data;
            REG_END_RULE:       rules.end_rule = data[9:0];
            REG_END_TIME_MS:    rules.end_time_ms = data;
            REG_DST_BIAS:       rules.dst_bias_minutes = data[11:0];
            default:            ;
        endcase
    endtask

    task automatic apply_setting(input logic en, input logic absolute, input logic [9:0] srule,
                                 input logic [26:0] stime, input logic [9:0] erule,
                                 input logic [26:0] etime, input logic signed [11:0] bias,
                                 input bit touch_unused);
        if (touch_unused)
        begin
            write_reg(REG_UNUSED, 27'($urandom));
        end
        write_reg(REG_DST_ENABLE, pad({26'd0, en}, 1));
        write_reg(REG_ABSOLUTE_RULES, pad({26'd0, absolute}, 1));
        write_reg(REG_START_RULE, pad({17'd0, srule}, 10));
        write_reg(REG_START_TIME_MS, stime);
        write_reg(REG_END_RULE, pad({17'd0, erule}, 10));
        write_reg(REG_END_TIME_MS, etime);
        write_reg(REG_DST_BIAS, pad({15'd0, bias}, 12));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_stamp(input int y, input int d, input int h, input int m, input int s);
        stamp_t st;
        st.yr = 8'(y);
        st.yday = 9'(d);
        st.hr = 5'(h);
        st.mn = 6'(m);
        st.sc = 6'(s);
        stamp_q.push_back(st);
    endtask

    // Start day at 02:00:00 and end day at 03:00:00, the start time and the biased end time of the US setting.
    task automatic push_transitions(input int y);
        push_stamp(y, int'(transition_day(8'(y), rules.start_rule)), 2, 0, 0);
        push_stamp(y, int'(transition_day(8'(y), rules.end_rule)), 3, 0, 0);
    endtask

    task automatic drain();
        while (stamp_q.size() != 0 || in_valid || pending_in_dst.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_setting(input int n_items);
        setting_count++;
        if (setting_count <= 12)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 79;
        end
        else if (setting_count <= 24)
        begin
            send_idle_pct = 79;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        repeat (n_items) stamp_q.push_back(random_stamp());
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
    begin : driver
        stamp_t s;
        if (!in_valid || in_taken)
        begin
            if (stamp_q.size() != 0 && !roll(send_idle_pct))
            begin
                s = stamp_q.pop_front();
                in_valid <= 1'b1;
                year_since_1900 <= s.yr;
                day_of_year <= s.yday;
                hour <= s.hr;
                minute <= s.mn;
                second <= s.sc;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= !roll(recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        stamp_t s;
        logic   want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (pending_in_dst.size() == 0)
                begin
                    $error("in_dst: no result expected, actual %0d", in_dst);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_in_dst.pop_front();
                    if (in_dst !== want)
                    begin
                        $error("in_dst: expected %0d, actual %0d", want, in_dst);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                s.yr = year_since_1900;
                s.yday = day_of_year;
                s.hr = hour;
                s.mn = minute;
                s.sc = second;
                pending_in_dst.push_back(dst_in_force(s));
            end
        end
    end

    initial
    begin : stimulus
        logic [9:0] us_start;
        logic [9:0] us_end;
        rules = '0;
        rules.dst_enable = 1'b1;
        us_start = make_rule(3, 2, 0);
        us_end = make_rule(11, 1, 0);
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values leave the start month at zero.
        run_setting(6);

        apply_setting(1'b1, 1'b0, us_start, 27'd7200000, us_end, 27'd7200000, 12'sd60, 1'b0);
        push_stamp(70, int'(transition_day(8'd70, us_start)), 1, 59, 59);
        push_stamp(70, int'(transition_day(8'd70, us_end)), 2, 59, 59);
        push_transitions(0);
        push_transitions(1);
        push_transitions(68);
        push_transitions(69);
        push_transitions(70);
        push_transitions(124);
        push_transitions(199);
        push_transitions(255);
        push_stamp(70, 0, 0, 0, 0);
        push_stamp(255, 511, 31, 63, 63);
        push_stamp(124, 200, 12, 30, 60);
        push_stamp(71, 365, 23, 59, 59);
        run_setting(6);

        apply_setting(1'b0, 1'b0, us_start, 27'd7200000, us_end, 27'd7200000, 12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b1, us_start, 27'd7200000, us_end, 27'd7200000, 12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(0, 2, 0), 27'd7200000, us_end, 27'd7200000,
                      12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(13, 2, 0), 27'd7200000, us_end, 27'd7200000,
                      12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, us_start, 27'd7200000, make_rule(0, 1, 0), 27'd7200000,
                      12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, us_start, 27'd7200000, make_rule(15, 1, 0), 27'd7200000,
                      12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(4, 0, 7), 27'd0, make_rule(9, 6, 3), 27'd3600000,
                      12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(2, 7, 7), 27'd3600500, make_rule(10, 5, 7),
                      27'd7200000, 12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(10, 1, 0), 27'd7200000, make_rule(4, 1, 0),
                      27'd10800000, 12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(3, 5, 0), 27'd3600000, make_rule(10, 5, 0), 27'd0,
                      -12'sd60, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(3, 5, 0), 27'd3600000, make_rule(10, 5, 0),
                      27'd86399999, 12'sd1440, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(1, 1, 6), 27'h7FFFFFF, make_rule(12, 5, 6),
                      27'h7FFFFFF, 12'sd2047, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(12, 5, 6), 27'd86399999, make_rule(1, 1, 0), 27'd0,
                      -12'sd2048, 1'b0);
        run_setting(15);
        apply_setting(1'b1, 1'b0, make_rule(6, 3, 2), 27'd43200000, make_rule(6, 3, 2),
                      27'd43200000, -12'sd1440, 1'b1);
        run_setting(15);

        repeat (20)
        begin
            apply_setting(roll(90), !roll(90), random_rule(), random_time_ms(), random_rule(),
                          random_time_ms(),
                          roll(80) ? 12'($signed($urandom_range(2880, 0)) - 1440)
                                   : 12'($urandom),
                          roll(10));
            run_setting(28);
        end

        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("dst_rule_check_unit_test: PASS");
        end
        else
        begin
            $display("dst_rule_check_unit_test: FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("dst_rule_check_unit_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/dst_pkg.sv
sv/dst_cfg_regs.sv
sv/dst_rule_day.sv
sv/dst_rule_check_unit.sv
tb/dst_rule_check_unit_test.sv
